// ===== rtl/hvt_pkg.sv =====
// Package with shared constants for the homogeneous vertex transform.
package hvt_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegWidth = 64;
  localparam int unsigned RegIdxWidth = 3;
  localparam int unsigned SumWidth = 66;
  localparam int unsigned WordWidth = 32;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusWZero = 2'd1;
  localparam logic [1:0] StatusSat = 2'd2;

  localparam logic KindPoint = 1'b0;
  localparam logic KindDirection = 1'b1;

endpackage

// ===== rtl/hvt_div_cell.sv =====
// One restoring-division cell: develops one quotient bit per cycle while en_i is high and hands on.
module hvt_div_cell #(
  parameter int unsigned NumW = 100,
  parameter int unsigned DenW = 66,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  rem_i,
  input  logic [NumW-1:0]  quo_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  rem_o,
  output logic [NumW-1:0]  quo_o,
  output logic [DenW-1:0]  den_o,
  output logic [SideW-1:0] side_o
);

  logic [NumW:0]    trial;
  logic [NumW-1:0]  rem_d, rem_q, quo_d, quo_q;
  logic [DenW-1:0]  den_q;
  logic [SideW-1:0] side_q;
  logic             valid_q;

  always_comb begin
    trial = {rem_i, quo_i[NumW-1]} - {{(NumW + 1 - DenW){1'b0}}, den_i};
    if (!trial[NumW]) begin
      rem_d = trial[NumW-1:0];
      quo_d = {quo_i[NumW-2:0], 1'b1};
    end else begin
      rem_d = {rem_i[NumW-2:0], quo_i[NumW-1]};
      quo_d = {quo_i[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/hvt_dot.sv =====
// Row dot product: three registered products, then a floor shift and sum stage.
module hvt_dot #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned CoordWidth = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [CoordWidth-1:0] e0_i,
  input  logic signed [CoordWidth-1:0] e1_i,
  input  logic signed [CoordWidth-1:0] e2_i,
  input  logic signed [CoordWidth-1:0] e3_i,
  input  logic                         use_off_i,
  input  logic signed [CoordWidth-1:0] x_i,
  input  logic signed [CoordWidth-1:0] y_i,
  input  logic signed [CoordWidth-1:0] z_i,
  output logic signed [hvt_pkg::SumWidth-1:0] sum_o
);

  localparam int unsigned PW = 2 * CoordWidth;
  localparam int unsigned SW = hvt_pkg::SumWidth;

  logic signed [PW-1:0] p0_q, p1_q, p2_q;
  logic signed [CoordWidth-1:0] off_q;
  logic signed [SW-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= e0_i * x_i;
      p1_q  <= e1_i * y_i;
      p2_q  <= e2_i * z_i;
      off_q <= use_off_i ? e3_i : '0;
      sum_q <= SW'(p0_q >>> FracBits) + SW'(p1_q >>> FracBits)
             + SW'(p2_q >>> FracBits) + SW'(off_q);
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/homogeneous_vertex_transform.sv =====
// Top level of the homogeneous vertex transform with perspective divide.
//
//  channel | direction | payload
//  s_axis  | in        | tuser: kind; tdata: in_x, in_y, in_z
//  m_axis  | out       | tdata: out_x, out_y, out_z, status
//  cfg     | in        | write enable, register index, 64-bit data
//
// One item per cycle while m_axis is not stalled. A result passes from its input
// transfer through an input register, a product stage, a sum stage, one division cell
// per quotient bit and the output register. Reset clears all valid bits and
// loads the identity matrix. A stall at m_axis freezes the whole chain.
module homogeneous_vertex_transform #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic          s_axis_tuser_i,  // kind
  input  logic [95:0]   s_axis_tdata_i,  // in_x, in_y, in_z
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [103:0]  m_axis_tdata_o   // out_x, out_y, out_z, status, zero pad
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = hvt_pkg::SumWidth;
  localparam int unsigned NW = SW + FRAC_BITS;
  localparam int unsigned NCELL = NW;
  localparam int unsigned SIDE = 2;
  localparam logic signed [NW:0] MaxV = (NW+1)'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [NW:0] MinV = -(NW+1)'(64'sd1 <<< (CW - 1));

  logic [63:0] regs_q [hvt_pkg::NumRegs];
  logic en;
  logic signed [CW-1:0] el [4][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= 64'h1_0000;
      regs_q[1] <= '0;
      regs_q[2] <= 64'h1_0000_0000_0000;
      regs_q[3] <= '0;
      regs_q[4] <= '0;
      regs_q[5] <= 64'h1_0000;
      regs_q[6] <= '0;
      regs_q[7] <= 64'h1_0000_0000_0000;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      el[r][0] = regs_q[2*r][CW-1:0];
      el[r][1] = regs_q[2*r][32+CW-1:32];
      el[r][2] = regs_q[2*r+1][CW-1:0];
      el[r][3] = regs_q[2*r+1][32+CW-1:32];
    end
  end

  // Front pipe: input register, product stage, sum stage.
  logic [2:0] fv_q;
  logic [2:0] fk_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [SW-1:0] sum [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[1:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fk_q <= {fk_q[1:0], s_axis_tuser_i};
      x_q  <= s_axis_tdata_i[CW-1:0];
      y_q  <= s_axis_tdata_i[32+CW-1:32];
      z_q  <= s_axis_tdata_i[64+CW-1:64];
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    hvt_dot #(.FracBits(FRAC_BITS), .CoordWidth(CW)) u_dot (
      .clk_i, .en_i(en), .e0_i(el[r][0]), .e1_i(el[r][1]), .e2_i(el[r][2]),
      .e3_i(el[r][3]), .use_off_i(fk_q[0] == hvt_pkg::KindPoint),
      .x_i(x_q), .y_i(y_q), .z_i(z_q), .sum_o(sum[r]));
  end

  // Dividend |sum| << FRAC_BITS over |w| (1 if w is 0); for a direction |sum| over 1.
  logic [NW-1:0] num [3];
  logic [SW-1:0] den;
  logic [SIDE-1:0] side [3];
  logic wz, dir;
  assign dir = fk_q[2];
  assign wz  = (sum[3] == '0);
  always_comb begin
    logic [SW-1:0] mag;
    den = sum[3][SW-1] ? SW'(-sum[3]) : SW'(sum[3]);
    if (dir || wz) den = SW'(1);
    for (int k = 0; k < 3; k++) begin
      mag = sum[k][SW-1] ? SW'(-sum[k]) : SW'(sum[k]);
      num[k] = dir ? NW'(mag) : {mag, {FRAC_BITS{1'b0}}};
      side[k] = {dir ? sum[k][SW-1] : (sum[k][SW-1] ^ sum[3][SW-1]), wz & ~dir};
    end
  end

  logic [NW-1:0] q_out [3];
  logic [SIDE-1:0] s_out [3];
  logic v_out [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic [NW-1:0] rem_c [NCELL+1];
    logic [NW-1:0] quo_c [NCELL+1];
    logic [SW-1:0] den_c [NCELL+1];
    logic [SIDE-1:0] sd_c [NCELL+1];
    logic v_c [NCELL+1];
    assign rem_c[0] = '0;
    assign quo_c[0] = num[k];
    assign den_c[0] = den;
    assign sd_c[0]  = side[k];
    assign v_c[0]   = fv_q[2];
    for (genvar c = 0; c < NCELL; c++) begin : g_cell
      hvt_div_cell #(.NumW(NW), .DenW(SW), .SideW(SIDE)) u_cell (
        .clk_i, .rst_ni, .en_i(en), .valid_i(v_c[c]), .rem_i(rem_c[c]),
        .quo_i(quo_c[c]), .den_i(den_c[c]), .side_i(sd_c[c]),
        .valid_o(v_c[c+1]), .rem_o(rem_c[c+1]), .quo_o(quo_c[c+1]),
        .den_o(den_c[c+1]), .side_o(sd_c[c+1]));
    end
    assign q_out[k] = quo_c[NCELL];
    assign s_out[k] = sd_c[NCELL];
    assign v_out[k] = v_c[NCELL];
  end

  // Output register with sign, saturation and status.
  logic ov_q;
  logic [103:0] od_q;
  logic [103:0] od_d;
  always_comb begin
    logic signed [NW:0] v;
    logic sat;
    sat = 1'b0;
    od_d = '0;
    for (int k = 0; k < 3; k++) begin
      v = s_out[k][1] ? -$signed({1'b0, q_out[k]}) : $signed({1'b0, q_out[k]});
      if (v > MaxV) begin
        v = MaxV; sat = 1'b1;
      end else if (v < MinV) begin
        v = MinV; sat = 1'b1;
      end
      if (s_out[0][0]) v = '0;
      od_d[32*k +: 32] = 32'(v);
    end
    od_d[97:96] = s_out[0][0] ? hvt_pkg::StatusWZero
                : (sat ? hvt_pkg::StatusSat : hvt_pkg::StatusOk);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= v_out[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od_q <= od_d;
    end
  end

  assign en = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = od_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed during stall");
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_out[0] == v_out[1] && v_out[1] == v_out[2])
    else $error("lanes out of step");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[97:96] != 2'd3)
    else $error("bad status");

endmodule
